// ===== sv/pnpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pnpm_pkg
// Shared types, constants and helpers for the palette nearest / pair match
// block: opcodes, widths, reset values and the per-channel blend.
// ----------------------------------------------------------------------------
package pnpm_pkg;

    // Palette geometry and widths
    localparam int unsigned PALETTE_ENTRIES_DEF = 16;
    localparam int unsigned COLOUR_W            = 24;
    localparam int unsigned DIST_W              = 18;
    localparam int unsigned INDEX_W             = 8;

    // Reset value of the pair limit and the result for "no pair found"
    localparam logic [DIST_W-1:0]  PAIR_LIMIT_RESET = 18'd90000;
    localparam logic [INDEX_W-1:0] NO_PAIR          = 8'hFF;

    // Opcodes carried in tuser
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_PAIR   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_PAIR,
        ST_RESULT
    } t_state;

    // Per-channel floor average of two RGB colours
    function automatic logic [COLOUR_W-1:0] blend(input logic [COLOUR_W-1:0] a,
                                                  input logic [COLOUR_W-1:0] b);
        logic [COLOUR_W-1:0] res;
        logic [8:0]          sum;
        res = '0;
        for (int c = 0; c < 3; c++) begin
            sum = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]};
            res[c*8 +: 8] = sum[8:1];
        end
        return res;
    endfunction

endpackage

// ===== sv/pnpm_ram.sv =====
// ----------------------------------------------------------------------------
// pnpm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pnpm_ram #(
    parameter  int unsigned WIDTH = 24,
    parameter  int unsigned DEPTH = 16,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read two
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== sv/pnpm_dist.sv =====
// ----------------------------------------------------------------------------
// pnpm_dist
// Shared distance unit: squared Euclidean distance between two RGB colours.
// ----------------------------------------------------------------------------
module pnpm_dist
    import pnpm_pkg::*;
(
    input  logic [COLOUR_W-1:0] i_a,
    input  logic [COLOUR_W-1:0] i_b,
    output logic [DIST_W-1:0]   o_dist
);

    logic [7:0]  diff [3];
    logic [15:0] sq   [3];

    // Take absolute channel differences and square them
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = (i_a[c*8 +: 8] > i_b[c*8 +: 8]) ? (i_a[c*8 +: 8] - i_b[c*8 +: 8])
                                                      : (i_b[c*8 +: 8] - i_a[c*8 +: 8]);
            sq[c]   = diff[c] * diff[c];
        end
    end

    // Sum the three squares
    assign o_dist = DIST_W'({2'b00, sq[0]}) + DIST_W'({2'b00, sq[1]})
                  + DIST_W'({2'b00, sq[2]});

endmodule

// ===== sv/palette_nearest_and_pair_match.sv =====
// ----------------------------------------------------------------------------
// palette_nearest_and_pair_match
// Palette store with nearest-entry and blended-pair colour search.
// ----------------------------------------------------------------------------
// A nearest match searches entries 1 to PALETTE_ENTRIES-1, a blended match every ordered
// pair of those entries (limit check then blend per pair), and a transparent query
// offers its result word the next cycle.
// One word at a time: input is ready again the cycle after the result word leaves,
// and stays ready after a write.
// Reset (synchronous, active low) blacks out the palette via valid bits, limit 90000.
// ----------------------------------------------------------------------------
module palette_nearest_and_pair_match
    import pnpm_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // entry_index[3:0], red[11:4], green[19:12],
                                     // blue[27:20], alpha[35:28], zero[39:36]
    input  logic [1:0]  i_s_tuser,   // opcode[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // colour_index[7:0]
    // pair limit register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [17:0] i_cfg_data
);

    localparam int unsigned AW       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [4:0]  NUM_ENT  = 5'(PALETTE_ENTRIES);
    localparam logic [3:0]  LAST_IDX = 4'(PALETTE_ENTRIES - 1);

    // Input word fields
    logic [3:0]          in_index;
    logic [COLOUR_W-1:0] in_colour;
    logic [7:0]          in_alpha;
    logic                in_accept;

    assign in_index  = i_s_tdata[3:0];
    assign in_colour = {i_s_tdata[11:4], i_s_tdata[19:12], i_s_tdata[27:20]};
    assign in_alpha  = i_s_tdata[35:28];
    assign in_accept = i_s_tvalid && o_s_tready;

    // Control and datapath registers
    t_state               r_state, n_state;
    logic [3:0]           r_x, n_x;
    logic [3:0]           r_y, n_y;
    logic                 r_phase, n_phase;
    logic                 r_pd_ok, n_pd_ok;
    logic                 r_found, n_found;
    logic [DIST_W-1:0]    r_best_d, n_best_d;
    logic [INDEX_W-1:0]   r_best, n_best;
    logic [INDEX_W-1:0]   r_result, n_result;
    logic [COLOUR_W-1:0]  r_query;
    logic [DIST_W-1:0]    r_limit;
    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic                 r_vld_x, r_vld_y;

    // Palette memory signals
    logic                 we;
    logic [COLOUR_W-1:0]  rd_x, rd_y;
    logic [COLOUR_W-1:0]  ent_x, ent_y;

    // Distance unit operands
    logic [COLOUR_W-1:0]  dist_a, dist_b;
    logic [DIST_W-1:0]    sq_dist;
    logic                 better;
    logic                 last_pair;

    // Write a palette entry only when it lies inside the palette
    assign we = in_accept && (i_s_tuser == OP_WRITE) && ({1'b0, in_index} < NUM_ENT);

    pnpm_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (in_index[AW-1:0]),
        .i_wdata   (in_colour),
        .i_raddr_a (n_x[AW-1:0]),
        .i_raddr_b (n_y[AW-1:0]),
        .o_rdata_a (rd_x),
        .o_rdata_b (rd_y)
    );

    // Entries never written read as black
    assign ent_x = r_vld_x ? rd_x : '0;
    assign ent_y = r_vld_y ? rd_y : '0;

    // Steer the shared distance unit
    always_comb begin
        dist_a = ent_x;
        dist_b = r_query;
        if (r_state == ST_PAIR) begin
            if (!r_phase) begin
                dist_a = ent_y;
                dist_b = ent_x;
            end else begin
                dist_a = blend(ent_x, ent_y);
            end
        end
    end

    pnpm_dist u_dist (
        .i_a    (dist_a),
        .i_b    (dist_b),
        .o_dist (sq_dist)
    );

    assign last_pair = (r_x == LAST_IDX) && (r_y == LAST_IDX);

    always_comb begin
        better = !r_found || (sq_dist < r_best_d);
        if (r_state == ST_PAIR) begin
            better = better && r_pd_ok;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_s_tuser)
                        OP_SINGLE: n_state = (in_alpha == 8'd0) ? ST_RESULT : ST_SINGLE;
                        OP_PAIR:   n_state = (in_alpha == 8'd0) ? ST_RESULT : ST_PAIR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SINGLE: begin
                if (r_x == LAST_IDX) begin
                    n_state = ST_RESULT;
                end
            end
            ST_PAIR: begin
                if (r_phase && last_pair) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_IDLE:   o_s_tready = 1'b1;
            ST_RESULT: o_m_tvalid = 1'b1;
            default: begin
                o_s_tready = 1'b0;
                o_m_tvalid = 1'b0;
            end
        endcase
    end

    assign o_m_tdata   = r_result;
    assign o_cfg_ready = 1'b1;

    // Walk candidates and track the best one
    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_phase  = r_phase;
        n_pd_ok  = r_pd_ok;
        n_found  = r_found;
        n_best_d = r_best_d;
        n_best   = r_best;
        n_result = r_result;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_x      = 4'd1;
                    n_y      = 4'd1;
                    n_phase  = 1'b0;
                    n_found  = 1'b0;
                    n_best   = (i_s_tuser == OP_PAIR) ? NO_PAIR : '0;
                    n_result = '0;
                end
            end
            ST_SINGLE: begin
                if (better) begin
                    n_found  = 1'b1;
                    n_best_d = sq_dist;
                    n_best   = {4'h0, r_x};
                end
                n_x = r_x + 4'd1;
                if (r_x == LAST_IDX) begin
                    n_result = better ? {4'h0, r_x} : r_best;
                end
            end
            ST_PAIR: begin
                if (!r_phase) begin
                    // check the two entries are close enough to blend
                    n_pd_ok = (sq_dist <= r_limit);
                    n_phase = 1'b1;
                end else begin
                    if (better) begin
                        n_found  = 1'b1;
                        n_best_d = sq_dist;
                        n_best   = {r_y, r_x};
                    end
                    n_phase = 1'b0;
                    if (r_x == LAST_IDX) begin
                        n_x = 4'd1;
                        n_y = r_y + 4'd1;
                    end else begin
                        n_x = r_x + 4'd1;
                    end
                    if (last_pair) begin
                        n_result = better ? {r_y, r_x} : r_best;
                    end
                end
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_limit <= PAIR_LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_valid[in_index[AW-1:0]] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_phase  <= n_phase;
        r_pd_ok  <= n_pd_ok;
        r_found  <= n_found;
        r_best_d <= n_best_d;
        r_best   <= n_best;
        r_result <= n_result;
        r_vld_x  <= r_valid[n_x[AW-1:0]];
        r_vld_y  <= r_valid[n_y[AW-1:0]];
        if (in_accept) begin
            r_query <= in_colour;
        end
    end

endmodule
